// ----- sv/ipid_pkg.sv -----
// Shared types and constants for the incremental pid core.
// Used by ipid_datapath and incremental_pid_saturated_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipid_pkg;

	// register indexes of the configuration port
	typedef enum logic [2:0] {
		REG_SETPOINT     = 3'd0,
		REG_GAIN_P       = 3'd1,
		REG_GAIN_I       = 3'd2,
		REG_GAIN_D       = 3'd3,
		REG_OUTPUT_RANGE = 3'd4
	} ipid_reg_t;

	localparam int TEMP_W  = 14;
	localparam int ERROR_W = 15;
	localparam int GAIN_W  = 16;
	localparam int DRIVE_W = 16;
	localparam int INDEX_W = 3;

	localparam logic signed [TEMP_W-1:0] SETPOINT_RESET = 14'sd176;
	localparam logic [GAIN_W-1:0]  GAIN_P_RESET       = 16'd2560;
	localparam logic [GAIN_W-1:0]  GAIN_I_RESET       = 16'd2560;
	localparam logic [GAIN_W-1:0]  GAIN_D_RESET       = 16'd51;
	localparam logic [DRIVE_W-1:0] OUTPUT_RANGE_RESET = 16'd1500;

	typedef struct packed {
		logic [DRIVE_W-1:0] drive;
		logic               clipped_high;
		logic               clipped_low;
	} ipid_result_t;

endpackage

`default_nettype wire

// ----- sv/ipid_datapath.sv -----
// Combinational pid increment, truncation and clamp for one sample.
// Depends on ipid_pkg; instantiated by incremental_pid_saturated_core.
`timescale 1ns / 1ps
`default_nettype none

module ipid_datapath import ipid_pkg::*; #(
	parameter int GAIN_FRACTION_BITS = 8
) (
	input  wire logic signed [TEMP_W-1:0]  setpoint,
	input  wire logic [GAIN_W-1:0]         gain_p,
	input  wire logic [GAIN_W-1:0]         gain_i,
	input  wire logic [GAIN_W-1:0]         gain_d,
	input  wire logic [DRIVE_W-1:0]        output_range,
	input  wire logic signed [TEMP_W-1:0]  measurement,
	input  wire logic signed [ERROR_W-1:0] prior_error,
	input  wire logic signed [ERROR_W-1:0] older_error,
	input  wire logic [DRIVE_W-1:0]        drive_acc,
	output logic signed [ERROR_W-1:0]      error,
	output ipid_result_t                   result
);

	localparam int ShiftBits = GAIN_FRACTION_BITS + 3;
	localparam int ProdW     = GAIN_W + 1 + ERROR_W + 3;
	localparam int AccW      = DRIVE_W + 1 + ShiftBits;
	localparam int SumW      = ((ProdW > AccW) ? ProdW : AccW) + 2;
	localparam logic signed [SumW-1:0] RoundBias = (SumW'(1) <<< ShiftBits) - SumW'(1);

	logic signed [ERROR_W:0]         diff1;
	logic signed [ERROR_W:0]         sum1;
	logic signed [ERROR_W+2:0]       diff2;
	logic signed [GAIN_W+ERROR_W+1:0] prod_p;
	logic signed [GAIN_W+ERROR_W+1:0] prod_i;
	logic signed [GAIN_W+ERROR_W+3:0] prod_d;
	logic signed [SumW-1:0]          total;
	logic signed [SumW-1:0]          whole;
	logic signed [SumW-1:0]          range_ext;

	assign error = ERROR_W'(setpoint) - ERROR_W'(measurement);

	assign diff1 = (ERROR_W+1)'(error) - (ERROR_W+1)'(prior_error);
	assign sum1  = (ERROR_W+1)'(error) + (ERROR_W+1)'(prior_error);
	assign diff2 = (ERROR_W+3)'(error) - ((ERROR_W+3)'(prior_error) <<< 1)
		+ (ERROR_W+3)'(older_error);

	assign prod_p = $signed({1'b0, gain_p}) * diff1;
	assign prod_i = $signed({1'b0, gain_i}) * sum1;
	assign prod_d = $signed({1'b0, gain_d}) * diff2;

	// stored drive scaled up plus the numerator, all in 2^-(fraction+3) units
	assign total = (SumW'($signed({1'b0, drive_acc})) <<< ShiftBits)
		+ (SumW'(prod_p) <<< 1) + SumW'(prod_i) + SumW'(prod_d);

	// truncate toward zero: bias negative values before the arithmetic shift
	assign whole = (total + (total[SumW-1] ? RoundBias : SumW'(0))) >>> ShiftBits;

	assign range_ext = SumW'($signed({1'b0, output_range}));

	always_comb begin
		result.drive        = whole[DRIVE_W-1:0];
		result.clipped_low  = 1'b0;
		result.clipped_high = 1'b0;
		if (whole[SumW-1]) begin
			result.drive       = '0;
			result.clipped_low = 1'b1;
		end else if (whole > range_ext) begin
			result.drive        = output_range;
			result.clipped_high = 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- sv/incremental_pid_saturated_core.sv -----
// Top level of the velocity-form pid heater controller.
// Depends on ipid_pkg and ipid_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Each measurement beat yields one drive beat. A sample is captured in an input
// register; then, when the output register can advance, the error, the three
// gain products, the truncated sum and the clamp are formed combinationally and
// land in the output register together with the updated error history and
// stored drive. One sample per cycle is sustained while m_axis_tready is high,
// set by that combinational path whose state feeds the next sample.
// A stalled result still lets one more sample into an empty input register;
// once both registers hold a beat, s_axis_tready follows m_axis_tready. Registers
// may be written only while no sample is in flight; cfg_ready is always high.
module incremental_pid_saturated_core import ipid_pkg::*; #(
	parameter int GAIN_FRACTION_BITS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [15:0]        s_axis_tdata,   // [13:0] measurement, [15:14] zero
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output logic [15:0]             m_axis_tdata,   // [15:0] drive
	output logic [1:0]              m_axis_tuser,   // [0] clipped_low, [1] clipped_high
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [INDEX_W-1:0] cfg_index,
	input  wire logic [15:0]        cfg_data
);

	logic signed [TEMP_W-1:0]  setpoint_q;
	logic [GAIN_W-1:0]         gain_p_q;
	logic [GAIN_W-1:0]         gain_i_q;
	logic [GAIN_W-1:0]         gain_d_q;
	logic [DRIVE_W-1:0]        output_range_q;

	logic signed [ERROR_W-1:0] prior_error_q;
	logic signed [ERROR_W-1:0] older_error_q;
	logic [DRIVE_W-1:0]        drive_acc_q;

	logic                      valid_s1;
	logic signed [TEMP_W-1:0]  meas_s1;
	logic                      valid_s2;
	ipid_result_t              result_s2;

	logic                      advance;
	logic signed [ERROR_W-1:0] error;
	ipid_result_t              result;

	assign cfg_ready     = 1'b1;
	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q     <= SETPOINT_RESET;
			gain_p_q       <= GAIN_P_RESET;
			gain_i_q       <= GAIN_I_RESET;
			gain_d_q       <= GAIN_D_RESET;
			output_range_q <= OUTPUT_RANGE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SETPOINT:     setpoint_q     <= cfg_data[TEMP_W-1:0];
				REG_GAIN_P:       gain_p_q       <= cfg_data;
				REG_GAIN_I:       gain_i_q       <= cfg_data;
				REG_GAIN_D:       gain_d_q       <= cfg_data;
				REG_OUTPUT_RANGE: output_range_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ipid_datapath #(
		.GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
	) u_datapath (
		.setpoint     (setpoint_q),
		.gain_p       (gain_p_q),
		.gain_i       (gain_i_q),
		.gain_d       (gain_d_q),
		.output_range (output_range_q),
		.measurement  (meas_s1),
		.prior_error  (prior_error_q),
		.older_error  (older_error_q),
		.drive_acc    (drive_acc_q),
		.error        (error),
		.result       (result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			meas_s1 <= s_axis_tdata[TEMP_W-1:0];
		end
	end

	// history and output register move together with each processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			prior_error_q <= '0;
			older_error_q <= '0;
			drive_acc_q   <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				prior_error_q <= error;
				older_error_q <= prior_error_q;
				drive_acc_q   <= result.drive;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = result_s2.drive;
	assign m_axis_tuser  = {result_s2.clipped_high, result_s2.clipped_low};

endmodule

`default_nettype wire
